/* rtl/disc_sector_transfer_engine_macros.svh */
// Assertion macros for the disc sector transfer engine.
// Used by rtl/disc_sector_transfer_engine.sv; expects aclk and aresetn in scope.
`ifndef DISC_SECTOR_TRANSFER_ENGINE_MACROS_SVH
`define DISC_SECTOR_TRANSFER_ENGINE_MACROS_SVH

// same-cycle implication
`define DSTE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dste: check failed");

// next-cycle implication
`define DSTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dste: check failed");

`endif

/* rtl/dste_pkg.sv */
// Shared codes, defaults and result type of the disc sector transfer engine.
// No dependencies.
package dste_pkg;

    localparam int SIDE_BUFFER_BYTES_DEF = 8192;
    localparam int POLL_DIVIDE_DEF       = 16;
    localparam int NOTFOUND_DELAY_DEF    = 500;

    localparam int CD_W  = 9;
    localparam int BP_W  = 11;
    localparam int LIN_W = 19;

    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_SEEK       = 3'd1;
    localparam logic [2:0] ACT_HOST_WRITE = 3'd2;
    localparam logic [2:0] ACT_HOST_READ  = 3'd3;
    localparam logic [2:0] ACT_READ_SEC   = 3'd4;
    localparam logic [2:0] ACT_WRITE_SEC  = 3'd5;
    localparam logic [2:0] ACT_READ_ADDR  = 3'd6;
    localparam logic [2:0] ACT_FORMAT     = 3'd7;

    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_DATA      = 3'd1;
    localparam logic [2:0] KIND_FINISHED  = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_WPROT     = 3'd4;
    localparam logic [2:0] KIND_HOST_READ = 3'd5;
    localparam logic [2:0] KIND_WRITEBACK = 3'd6;
    localparam logic [2:0] KIND_TAKEN     = 3'd7;

    localparam logic [2:0] CFG_DISK_PRESENT  = 3'd0;
    localparam logic [2:0] CFG_DOUBLE_SIDED  = 3'd1;
    localparam logic [2:0] CFG_SECTORS       = 3'd2;
    localparam logic [2:0] CFG_SIZE_CODE     = 3'd3;
    localparam logic [2:0] CFG_DOUBLE_STEP   = 3'd4;
    localparam logic [2:0] CFG_WRITE_PROTECT = 3'd5;

    localparam logic [1:0] SIZE_256 = 2'd0;
    localparam logic [1:0] SIZE_512 = 2'd1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic       final_byte;
    } res_t;

endpackage

/* rtl/disc_sector_transfer_engine.sv */
// Disc sector transfer engine: track buffer memory and byte-transfer sequencer.
// Depends on rtl/dste_pkg.sv and rtl/disc_sector_transfer_engine_macros.svh.
// Timing: the buffer is read at the accepting edge, state is updated in the
// following cycle and the results then leave one per cycle while m_tready is high.
// An item gives 0 to 4 results; no new item is accepted until the last is taken.
// Reset clears the state, control and config registers; the captured item, the
// results and the buffer contents are not reset and stay undefined.
module disc_sector_transfer_engine #(
    parameter int SIDE_BUFFER_BYTES = dste_pkg::SIDE_BUFFER_BYTES_DEF,
    parameter int POLL_DIVIDE       = dste_pkg::POLL_DIVIDE_DEF,
    parameter int NOTFOUND_DELAY    = dste_pkg::NOTFOUND_DELAY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // track, side, sector, density, offset, data_byte, data_valid
    input  logic [39:0] s_tdata,
    // action
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_value, final_byte, zero fill
    output logic [15:0] m_tdata,
    // kind
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_wdata
);
    import dste_pkg::*;

    localparam int ADDR_W = $clog2(2 * SIDE_BUFFER_BYTES);
    localparam int TW     = $clog2(POLL_DIVIDE + 1);
    localparam logic [LIN_W-1:0]  SIDE_LIN  = LIN_W'(SIDE_BUFFER_BYTES);
    localparam logic [ADDR_W-1:0] SIDE_ADDR = ADDR_W'(SIDE_BUFFER_BYTES);

    typedef enum logic [1:0] {ST_IDLE, ST_PROC, ST_EMIT} state_t;

    state_t state_reg;

    logic       present_reg, ds_reg, dstep_reg, wp_reg;
    logic [4:0] spt_reg;
    logic [1:0] code_reg;

    logic [TW-1:0]   td_reg, td_next;
    logic [CD_W-1:0] cd_reg, cd_next;
    logic            br_reg, br_next, bw_reg, bw_next;
    logic            bi_reg, bi_next, bf_reg, bf_next;
    logic [BP_W-1:0] bp_reg, bp_next;
    logic [7:0]      as_reg, as_next, at_reg, at_next, ct_reg, ct_next;
    logic            asd_reg, asd_next;
    logic [3:0]      idc_reg, idc_next;

    logic [2:0]  act_reg;
    logic [7:0]  trk_reg, sec_reg, db_reg;
    logic        side_reg, dens_reg, dv_reg;
    logic [12:0] off_reg;

    res_t       res_reg [4];
    res_t       res_next [4];
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg;

    logic [7:0]        mem [2 * SIDE_BUFFER_BYTES];
    logic [7:0]        mem_q;
    logic              mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [7:0]        mem_wdata;

    logic [BP_W-1:0]   size_bytes;
    logic [LIN_W-1:0]  sec_lin;
    logic              sec_ok;
    logic [ADDR_W-1:0] sec_addr;

    function automatic logic host_ok(input logic [12:0] off);
        host_ok = LIN_W'(off) < SIDE_LIN;
    endfunction

    function automatic logic [ADDR_W-1:0] host_addr(input logic side, input logic [12:0] off);
        logic [LIN_W-1:0] lin;
        lin = LIN_W'(off);
        host_addr = (side ? SIDE_ADDR : '0) + lin[ADDR_W-1:0];
    endfunction

    always_comb begin
        case (code_reg)
            SIZE_256: size_bytes = BP_W'(256);
            SIZE_512: size_bytes = BP_W'(512);
            default:  size_bytes = BP_W'(1024);
        endcase
    end

    always_comb begin
        case (code_reg)
            SIZE_256: sec_lin = {LIN_W'(as_reg)} << 8;
            SIZE_512: sec_lin = {LIN_W'(as_reg)} << 9;
            default:  sec_lin = {LIN_W'(as_reg)} << 10;
        endcase
        sec_lin  = sec_lin + LIN_W'(bp_reg);
        sec_ok   = sec_lin < SIDE_LIN;
        sec_addr = (asd_reg ? SIDE_ADDR : '0) + sec_lin[ADDR_W-1:0];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign mem_re    = s_tvalid && s_tready;
    assign mem_raddr = (s_tuser == ACT_HOST_READ) ? host_addr(s_tdata[8], s_tdata[30:18])
                                                  : sec_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_comb begin
        logic [2:0]      n;
        logic [TW-1:0]   td_sum;
        logic [BP_W-1:0] bp_inc;
        logic [4:0]      idc_inc;
        logic [7:0]      as_inc, trk;
        logic            stop;
        n       = '0;
        td_sum  = td_reg + TW'(1);
        bp_inc  = bp_reg + BP_W'(1);
        idc_inc = {1'b0, idc_reg} + 5'd1;
        as_inc  = as_reg + 8'd1;
        trk     = trk_reg;
        stop    = 1'b0;

        td_next = td_reg;  cd_next = cd_reg;
        br_next = br_reg;  bw_next = bw_reg;  bi_next = bi_reg;  bf_next = bf_reg;
        bp_next = bp_reg;  as_next = as_reg;  at_next = at_reg;  asd_next = asd_reg;
        ct_next = ct_reg;  idc_next = idc_reg;
        mem_we = 1'b0;  mem_waddr = sec_addr;  mem_wdata = '0;
        for (int i = 0; i < 4; i++) begin
            res_next[i] = '0;
        end

        case (act_reg)
            ACT_TICK: begin
                if (td_sum >= TW'(POLL_DIVIDE)) begin
                    td_next = '0;
                    if (cd_reg != '0) begin
                        cd_next = cd_reg - CD_W'(1);
                        if (cd_next == '0) begin
                            res_next[n[1:0]] = '{KIND_NOT_FOUND, 8'd0, 1'b0};
                            n = n + 3'd1;
                        end
                    end
                    if (br_reg && present_reg) begin
                        res_next[n[1:0]] = '{KIND_DATA, sec_ok ? mem_q : 8'd0, 1'b0};
                        n = n + 3'd1;
                        bp_next = bp_inc;
                        if (bp_inc >= size_bytes) begin
                            br_next = 1'b0;
                            res_next[n[1:0]] = '{KIND_FINISHED, 8'd0, 1'b0};
                            n = n + 3'd1;
                        end
                    end
                    if (bw_reg && present_reg) begin
                        if (wp_reg) begin
                            res_next[n[1:0]] = '{KIND_WPROT, 8'd0, 1'b0};
                            n = n + 3'd1;
                            bw_next = 1'b0;
                            stop = 1'b1;
                        end else if (dv_reg) begin
                            res_next[n[1:0]] = '{KIND_TAKEN, 8'd0,
                                                 bp_reg == size_bytes - BP_W'(1)};
                            n = n + 3'd1;
                            mem_we    = sec_ok;
                            mem_wdata = db_reg;
                            bp_next   = bp_inc;
                            if (bp_inc >= size_bytes) begin
                                bw_next = 1'b0;
                                res_next[n[1:0]] = '{KIND_FINISHED, 8'd0, 1'b0};
                                n = n + 3'd1;
                                res_next[n[1:0]] = '{KIND_WRITEBACK, 8'd0, 1'b0};
                                n = n + 3'd1;
                            end
                        end
                    end
                    if (bi_reg && present_reg && !stop) begin
                        case (bp_reg)
                            BP_W'(0): res_next[n[1:0]] = '{KIND_DATA, at_reg, 1'b0};
                            BP_W'(1): res_next[n[1:0]] = '{KIND_DATA, {7'd0, asd_reg}, 1'b0};
                            BP_W'(2): res_next[n[1:0]] = '{KIND_DATA,
                                          {4'd0, idc_reg} + {7'd0, code_reg != SIZE_256}, 1'b0};
                            BP_W'(3): res_next[n[1:0]] = '{KIND_DATA,
                                          (code_reg == SIZE_256) ? 8'd1 :
                                          (code_reg == SIZE_512) ? 8'd2 : 8'd3, 1'b0};
                            BP_W'(4), BP_W'(5): res_next[n[1:0]] = '{KIND_DATA, 8'd0, 1'b0};
                            default: begin
                                bi_next = 1'b0;
                                res_next[n[1:0]] = '{KIND_FINISHED, 8'd0, 1'b0};
                                idc_next = (idc_inc >= spt_reg) ? 4'd0 : idc_inc[3:0];
                            end
                        endcase
                        n = n + 3'd1;
                        bp_next = bp_inc;
                    end
                    if (bf_reg && present_reg && !stop) begin
                        if (wp_reg) begin
                            res_next[n[1:0]] = '{KIND_WPROT, 8'd0, 1'b0};
                            n = n + 3'd1;
                            bf_next = 1'b0;
                        end else begin
                            mem_we  = sec_ok;
                            bp_next = bp_inc;
                            if (bp_inc >= size_bytes) begin
                                bp_next = '0;
                                as_next = as_inc;
                                if ({3'd0, spt_reg} <= as_inc) begin
                                    bf_next = 1'b0;
                                    res_next[n[1:0]] = '{KIND_FINISHED, 8'd0, 1'b0};
                                    n = n + 3'd1;
                                    res_next[n[1:0]] = '{KIND_WRITEBACK, 8'd0, 1'b0};
                                    n = n + 3'd1;
                                end
                            end
                        end
                    end
                end else begin
                    td_next = td_sum;
                end
            end
            ACT_SEEK: begin
                if (present_reg) begin
                    ct_next = dstep_reg ? {1'b0, trk_reg[7:1]} : trk_reg;
                end
            end
            ACT_HOST_WRITE: begin
                mem_we    = host_ok(off_reg);
                mem_waddr = host_addr(side_reg, off_reg);
                mem_wdata = db_reg;
            end
            ACT_HOST_READ: begin
                res_next[0] = '{KIND_HOST_READ, host_ok(off_reg) ? mem_q : 8'd0, 1'b0};
                n = 3'd1;
            end
            default: begin
                br_next = 1'b0;  bw_next = 1'b0;  bi_next = 1'b0;  bf_next = 1'b0;
                if ((act_reg == ACT_READ_ADDR || act_reg == ACT_FORMAT) && dstep_reg) begin
                    trk = {1'b0, trk_reg[7:1]};
                end
                at_next  = trk;
                asd_next = side_reg;
                if (act_reg == ACT_READ_SEC || act_reg == ACT_WRITE_SEC) begin
                    as_next = sec_reg - {7'd0, code_reg != SIZE_256};
                end
                if (!present_reg || (side_reg && !ds_reg) || !dens_reg || trk != ct_reg) begin
                    cd_next = CD_W'(NOTFOUND_DELAY);
                end else begin
                    bp_next = '0;
                    case (act_reg)
                        ACT_READ_SEC:  br_next = 1'b1;
                        ACT_WRITE_SEC: bw_next = 1'b1;
                        ACT_READ_ADDR: bi_next = 1'b1;
                        default: begin
                            as_next = '0;
                            bf_next = 1'b1;
                        end
                    endcase
                end
            end
        endcase
        if (state_reg != ST_PROC) begin
            mem_we = 1'b0;
        end
        cnt_next = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            present_reg <= 1'b0;  ds_reg <= 1'b0;  spt_reg <= 5'd16;
            code_reg    <= SIZE_256;  dstep_reg <= 1'b0;  wp_reg <= 1'b0;
            td_reg <= '0;  cd_reg <= '0;
            br_reg <= 1'b0;  bw_reg <= 1'b0;  bi_reg <= 1'b0;  bf_reg <= 1'b0;
            bp_reg <= '0;  as_reg <= '0;  at_reg <= '0;  asd_reg <= 1'b0;
            ct_reg <= '0;  idc_reg <= '0;
            cnt_reg <= '0;  idx_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DISK_PRESENT:  present_reg <= cfg_wdata[0];
                    CFG_DOUBLE_SIDED:  ds_reg      <= cfg_wdata[0];
                    CFG_SECTORS:       spt_reg     <= cfg_wdata;
                    CFG_SIZE_CODE:     code_reg    <= cfg_wdata[1:0];
                    CFG_DOUBLE_STEP:   dstep_reg   <= cfg_wdata[0];
                    CFG_WRITE_PROTECT: wp_reg      <= cfg_wdata[0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        act_reg  <= s_tuser;
                        trk_reg  <= s_tdata[7:0];
                        side_reg <= s_tdata[8];
                        sec_reg  <= s_tdata[16:9];
                        dens_reg <= s_tdata[17];
                        off_reg  <= s_tdata[30:18];
                        db_reg   <= s_tdata[38:31];
                        dv_reg   <= s_tdata[39];
                        state_reg <= ST_PROC;
                    end
                end
                ST_PROC: begin
                    td_reg <= td_next;  cd_reg <= cd_next;
                    br_reg <= br_next;  bw_reg <= bw_next;  bi_reg <= bi_next;  bf_reg <= bf_next;
                    bp_reg <= bp_next;  as_reg <= as_next;  at_reg <= at_next;
                    asd_reg <= asd_next;  ct_reg <= ct_next;  idc_reg <= idc_next;
                    res_reg <= res_next;
                    cnt_reg <= cnt_next;
                    idx_reg <= '0;
                    state_reg <= (cnt_next != '0) ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        idx_reg <= idx_reg + 2'd1;
                        if ({1'b0, idx_reg} + 3'd1 == cnt_reg) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tuser  = res_reg[idx_reg].kind;
    assign m_tdata  = {7'd0, res_reg[idx_reg].final_byte, res_reg[idx_reg].byte_value};
    assign m_tlast  = ({1'b0, idx_reg} + 3'd1 == cnt_reg);

`include "disc_sector_transfer_engine_macros.svh"

    `DSTE_ASSERT_NOW(a_busy_excl, 1'b1, $onehot0({br_reg, bw_reg, bi_reg, bf_reg}))
    `DSTE_ASSERT_NOW(a_sides_apart, s_tready, !m_tvalid)
    `DSTE_ASSERT_NOW(a_emit_count, m_tvalid, cnt_reg != 3'd0 && {1'b0, idx_reg} < cnt_reg)
    `DSTE_ASSERT_NEXT(a_host_read_result, state_reg == ST_PROC && act_reg == ACT_HOST_READ, m_tvalid)

endmodule

/* bench/tb.sv */
// Testbench for disc_sector_transfer_engine: directed and random transfers
// checked against a behavioural predictor of the drive. Needs rtl/dste_pkg.sv.
`timescale 1ns / 100ps

module tb;
    import dste_pkg::*;

    localparam int SIDE_BYTES = 8192;
    localparam int POLL_DIV   = 16;
    localparam int NF_DELAY   = 500;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic       final_byte;
        logic       last;
    } drive_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [4:0]  cfg_wdata = '0;

    disc_sector_transfer_engine i_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic [7:0]  pbuf [2*SIDE_BYTES];
    bit          written [2*SIDE_BYTES];
    logic        present, dsided, dstep, wprot;
    logic [4:0]  spt;
    logic [1:0]  szc;
    logic [3:0]  tdiv;
    logic [8:0]  nf_count;
    logic        rd_busy, wr_busy, id_busy, fmt_busy;
    logic [10:0] bpos;
    logic [7:0]  act_sec, act_trk, cur_trk;
    logic        act_side;
    logic [3:0]  id_ctr;

    drive_res_t  expected_q[$];
    int          errors = 0;
    int          wdog = 0;
    bit          quiet = 0;
    bit          hold_off = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic int sbytes();
        return szc == 2'd0 ? 256 : (szc == 2'd1 ? 512 : 1024);
    endfunction

    function automatic void push(input logic [2:0] k, input logic [7:0] b, input logic f);
        drive_res_t r;
        r = '{kind: k, byte_value: b, final_byte: f, last: 1'b0};
        expected_q.push_back(r);
    endfunction

    function automatic int sec_addr();
        int a;
        a = int'(act_sec) * sbytes() + int'(bpos);
        return a >= SIDE_BYTES ? -1 : int'(act_side) * SIDE_BYTES + a;
    endfunction

    function automatic void drive_poll(input logic [7:0] db, input logic dv);
        int a;
        if (nf_count != 9'd0) begin
            nf_count = nf_count - 9'd1;
            if (nf_count == 9'd0) push(KIND_NOT_FOUND, 8'd0, 1'b0);
        end
        if (rd_busy && present) begin
            a = sec_addr();
            push(KIND_DATA, a < 0 ? 8'd0 : pbuf[a], 1'b0);
            bpos = bpos + 11'd1;
            if (int'(bpos) >= sbytes()) begin
                rd_busy = 1'b0;
                push(KIND_FINISHED, 8'd0, 1'b0);
            end
        end
        if (wr_busy && present) begin
            if (wprot) begin
                push(KIND_WPROT, 8'd0, 1'b0);
                wr_busy = 1'b0;
                return;
            end
            if (!dv) return;
            push(KIND_TAKEN, 8'd0, int'(bpos) == sbytes() - 1);
            a = sec_addr();
            if (a >= 0) begin
                pbuf[a] = db;
                written[a] = 1'b1;
            end
            bpos = bpos + 11'd1;
            if (int'(bpos) >= sbytes()) begin
                wr_busy = 1'b0;
                push(KIND_FINISHED, 8'd0, 1'b0);
                push(KIND_WRITEBACK, 8'd0, 1'b0);
            end
        end
        if (id_busy && present) begin
            case (bpos)
                11'd0: push(KIND_DATA, act_trk, 1'b0);
                11'd1: push(KIND_DATA, {7'd0, act_side}, 1'b0);
                11'd2: push(KIND_DATA, 8'(id_ctr) + 8'(szc != 2'd0), 1'b0);
                11'd3: push(KIND_DATA, szc == 2'd0 ? 8'd1 : (szc == 2'd1 ? 8'd2 : 8'd3), 1'b0);
                11'd4, 11'd5: push(KIND_DATA, 8'd0, 1'b0);
                default: begin
                    id_busy = 1'b0;
                    push(KIND_FINISHED, 8'd0, 1'b0);
                    id_ctr = (int'(id_ctr) + 1 >= int'(spt)) ? 4'd0 : id_ctr + 4'd1;
                end
            endcase
            bpos = bpos + 11'd1;
        end
        if (fmt_busy && present) begin
            if (wprot) begin
                push(KIND_WPROT, 8'd0, 1'b0);
                fmt_busy = 1'b0;
                return;
            end
            a = sec_addr();
            if (a >= 0) begin
                pbuf[a] = 8'd0;
                written[a] = 1'b1;
            end
            bpos = bpos + 11'd1;
            if (int'(bpos) >= sbytes()) begin
                bpos = 11'd0;
                act_sec = act_sec + 8'd1;
                if (act_sec >= {3'd0, spt}) begin
                    fmt_busy = 1'b0;
                    push(KIND_FINISHED, 8'd0, 1'b0);
                    push(KIND_WRITEBACK, 8'd0, 1'b0);
                end
            end
        end
    endfunction

    function automatic void predict_drive(input logic [2:0] act, input logic [7:0] trk,
            input logic sd, input logic [7:0] sec, input logic dens,
            input logic [12:0] off, input logic [7:0] db, input logic dv);
        int n0;
        n0 = expected_q.size();
        if (act >= ACT_READ_SEC) begin
            rd_busy = 1'b0; wr_busy = 1'b0; id_busy = 1'b0; fmt_busy = 1'b0;
            if (act >= ACT_READ_ADDR && dstep) trk = {1'b0, trk[7:1]};
            act_trk = trk;
            act_side = sd;
            if (act <= ACT_WRITE_SEC) act_sec = sec - 8'(szc != 2'd0);
            if (!present || (sd && !dsided) || !dens || trk != cur_trk) begin
                nf_count = 9'(NF_DELAY);
            end else begin
                bpos = 11'd0;
                case (act)
                    ACT_READ_SEC:  rd_busy = 1'b1;
                    ACT_WRITE_SEC: wr_busy = 1'b1;
                    ACT_READ_ADDR: id_busy = 1'b1;
                    default: begin
                        act_sec = 8'd0;
                        fmt_busy = 1'b1;
                    end
                endcase
            end
        end else begin
            case (act)
                ACT_TICK: begin
                    if (int'(tdiv) + 1 >= POLL_DIV) begin
                        tdiv = 4'd0;
                        drive_poll(db, dv);
                    end else begin
                        tdiv = tdiv + 4'd1;
                    end
                end
                ACT_SEEK: if (present) cur_trk = dstep ? {1'b0, trk[7:1]} : trk;
                ACT_HOST_WRITE: begin
                    pbuf[int'(sd) * SIDE_BYTES + int'(off)] = db;
                    written[int'(sd) * SIDE_BYTES + int'(off)] = 1'b1;
                end
                default: push(KIND_HOST_READ, pbuf[int'(sd) * SIDE_BYTES + int'(off)], 1'b0);
            endcase
        end
        if (expected_q.size() > n0) expected_q[$].last = 1'b1;
    endfunction

    function automatic void reset_drive();
        present = 1'b0; dsided = 1'b0; spt = 5'd16; szc = 2'd0; dstep = 1'b0;
        wprot = 1'b0; tdiv = 4'd0; nf_count = 9'd0;
        rd_busy = 1'b0; wr_busy = 1'b0; id_busy = 1'b0; fmt_busy = 1'b0;
        bpos = 11'd0; act_sec = 8'd0; act_trk = 8'd0; act_side = 1'b0;
        cur_trk = 8'd0; id_ctr = 4'd0;
    endfunction

    task automatic send_item(input logic [2:0] act, input logic [7:0] trk, input logic sd,
            input logic [7:0] sec, input logic dens, input logic [12:0] off,
            input logic [7:0] db, input logic dv);
        logic [2:0]  a;
        logic        s;
        logic [12:0] o;
        int          ra;
        a = act;
        s = sd;
        o = off;
        ra = -1;
        if (act == ACT_TICK && int'(tdiv) + 1 >= POLL_DIV && rd_busy && present)
            ra = sec_addr();
        // keep every buffer read on bytes that have been written
        if (act == ACT_HOST_READ && !written[int'(sd) * SIDE_BYTES + int'(off)]) begin
            a = ACT_HOST_WRITE;
        end else if (ra >= 0 && !written[ra]) begin
            a = ACT_HOST_WRITE;
            s = act_side;
            o = 13'(ra - int'(act_side) * SIDE_BYTES);
        end
        s_tuser <= a;
        s_tdata <= {dv, db, o, dens, sec, s, trk};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_drive(a, trk, s, sec, dens, o, db, dv);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DISK_PRESENT:  present = val[0];
            CFG_DOUBLE_SIDED:  dsided = val[0];
            CFG_SECTORS:       spt = val;
            CFG_SIZE_CODE:     szc = val[1:0];
            CFG_DOUBLE_STEP:   dstep = val[0];
            default:           wprot = val[0];
        endcase
    endtask

    task automatic ticks(input int n, input logic dv);
        repeat (n) send_item(ACT_TICK, 8'($urandom), 1'($urandom), 8'($urandom),
            1'($urandom), 13'($urandom), 8'($urandom), dv);
    endtask

    task automatic test_directed();
        write_reg(CFG_DISK_PRESENT, 5'd1);
        write_reg(CFG_DOUBLE_SIDED, 5'd1);
        write_reg(CFG_SECTORS, 5'd1);
        write_reg(CFG_SIZE_CODE, 5'd0);
        write_reg(CFG_DOUBLE_STEP, 5'd0);
        write_reg(CFG_WRITE_PROTECT, 5'd0);
        send_item(ACT_HOST_WRITE, 8'd0, 1'b1, 8'd0, 1'b0, 13'h1FFF, 8'hFF, 1'b1);
        send_item(ACT_HOST_READ, 8'd0, 1'b1, 8'd0, 1'b0, 13'h1FFF, 8'd0, 1'b0);
        send_item(ACT_HOST_WRITE, 8'd0, 1'b0, 8'd0, 1'b0, 13'd0, 8'h00, 1'b0);
        send_item(ACT_HOST_READ, 8'd0, 1'b0, 8'd0, 1'b0, 13'd0, 8'd0, 1'b0);
        send_item(ACT_SEEK, 8'hFF, 1'b0, 8'd0, 1'b0, 13'd0, 8'd0, 1'b0);
        send_item(ACT_SEEK, 8'd0, 1'b0, 8'd0, 1'b0, 13'd0, 8'd0, 1'b0);
        send_item(ACT_READ_ADDR, 8'd0, 1'b0, 8'd0, 1'b1, 13'd0, 8'd0, 1'b0);
        ticks(POLL_DIV * 7, 1'b0);
        send_item(ACT_READ_SEC, 8'd0, 1'b0, 8'hFF, 1'b0, 13'd0, 8'd0, 1'b0);
        send_item(ACT_WRITE_SEC, 8'd0, 1'b0, 8'hFF, 1'b1, 13'd0, 8'd0, 1'b0);
        ticks(POLL_DIV * 2, 1'b1);
        send_item(ACT_FORMAT, 8'd0, 1'b1, 8'd0, 1'b1, 13'd0, 8'd0, 1'b0);
        ticks(POLL_DIV * 2, 1'b0);
        settle();
        write_reg(CFG_WRITE_PROTECT, 5'd1);
        send_item(ACT_FORMAT, 8'd0, 1'b0, 8'd0, 1'b1, 13'd0, 8'd0, 1'b0);
        ticks(POLL_DIV, 1'b0);
        send_item(ACT_WRITE_SEC, 8'd0, 1'b0, 8'd0, 1'b1, 13'd0, 8'd0, 1'b0);
        ticks(POLL_DIV, 1'b1);
        settle();
        write_reg(CFG_WRITE_PROTECT, 5'd0);
    endtask

    task automatic test_notfound();
        write_reg(CFG_DISK_PRESENT, 5'd0);
        send_item(ACT_SEEK, 8'd9, 1'b0, 8'd0, 1'b1, 13'd0, 8'd0, 1'b0);
        send_item(ACT_READ_SEC, 8'd0, 1'b0, 8'd1, 1'b1, 13'd0, 8'd0, 1'b0);
        ticks(POLL_DIV, 1'b0);
        settle();
        write_reg(CFG_DISK_PRESENT, 5'd1);
    endtask

    // sector commands followed by 24 random ticks or host reads
    task automatic test_transfers(input int rounds);
        logic [2:0] cmd;
        logic [7:0] sec;
        logic [7:0] trk;
        logic       sd;
        for (int r = 0; r < rounds; r++) begin
            settle();
            write_reg(CFG_SIZE_CODE, ($urandom_range(0, 9) == 0) ? 5'd2
                                                                 : 5'($urandom_range(0, 1)));
            write_reg(CFG_SECTORS, ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                               : 5'($urandom_range(1, 2)));
            write_reg(CFG_DOUBLE_SIDED, 5'($urandom_range(0, 1)));
            write_reg(CFG_DOUBLE_STEP, 5'($urandom_range(0, 1)));
            write_reg(CFG_WRITE_PROTECT, {4'd0, $urandom_range(0, 5) == 0});
            sd = 1'($urandom);
            sec = (szc == 2'd0) ? 8'($urandom_range(0, 33)) : 8'($urandom_range(0, 9));
            send_item(ACT_SEEK, 8'($urandom_range(0, 3)), 1'b0, 8'd0, 1'b0, 13'd0, 8'd0, 1'b0);
            cmd = 3'($urandom_range(4, 7));
            trk = (dstep && cmd >= ACT_READ_ADDR) ? cur_trk << 1 : cur_trk;
            send_item(cmd, trk, sd, sec, $urandom_range(0, 7) != 0, 13'd0, 8'd0, 1'b0);
            for (int k = 0; k < 24; k++) begin
                send_item($urandom_range(0, 19) == 0 ? ACT_HOST_READ : ACT_TICK,
                    8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                    13'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, 3) != 0);
            end
        end
    endtask

    task automatic test_backpressure();
        settle();
        write_reg(CFG_SIZE_CODE, 5'd0);
        write_reg(CFG_WRITE_PROTECT, 5'd0);
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < 12; i++)
            send_item(ACT_HOST_READ, 8'd0, 1'b0, 8'd0, 1'b0, 13'd0, 8'd0, 1'b0);
        settle();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_item(3'($urandom_range(0, 7) < 5 ? $urandom_range(0, 3) : $urandom_range(0, 7)),
                8'($urandom_range(0, 3)), 1'($urandom), 8'($urandom), 1'($urandom),
                13'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_final(input int count);
        quiet = 1'b1;
        test_random(count);
        settle();
    endtask

    always @(posedge aclk) begin
        drive_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kind: m_tuser, byte_value: m_tdata[7:0], final_byte: m_tdata[8],
                    last: m_tlast};
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d", got.kind));
            end else begin
                want = expected_q.pop_front();
                if (got.kind != want.kind)
                    report($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.byte_value != want.byte_value)
                    report($sformatf("byte %0h, want %0h", got.byte_value, want.byte_value));
                if (got.final_byte != want.final_byte)
                    report($sformatf("final flag %0b, want %0b", got.final_byte,
                        want.final_byte));
                if (got.last != want.last)
                    report($sformatf("last %0b, want %0b", got.last, want.last));
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else if (quiet) m_tready <= 1'b1;
        else if ($urandom_range(0, 5) == 0) m_tready <= ~m_tready;
        else m_tready <= m_tready | ($urandom_range(0, 10) == 0);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn ||
                (!s_tvalid && expected_q.size() == 0))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        reset_drive();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_notfound();
        test_backpressure();
        test_transfers(3);
        test_random(30);
        settle();
        test_final(20);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
